// ===== rtl/rpn_pkg.sv =====
// Shared constants, types and helper functions for the RPN stack calculator.
// Used by the divider and the top level; depends on nothing else.
package rpn_pkg;

    // Stack geometry
    localparam int STACK_SLOTS = 64;
    localparam int CAPACITY    = STACK_SLOTS - 1;
    localparam int DEPTH_W     = $clog2(STACK_SLOTS);
    localparam int ADDR_W      = $clog2(CAPACITY);

    // Field widths
    localparam int VAL_W       = 32;
    localparam int OP_W        = 3;
    localparam int ST_W        = 3;
    localparam int OUT_DEPTH_W = 6;
    localparam int FRAC_W      = 16;

    // Opcodes
    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
    localparam logic [OP_W-1:0] OP_POP  = 3'd5;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 3'd0;
    localparam logic [ST_W-1:0] ST_OVER  = 3'd1;
    localparam logic [ST_W-1:0] ST_UNDER = 3'd2;
    localparam logic [ST_W-1:0] ST_DIVZ  = 3'd3;
    localparam logic [ST_W-1:0] ST_SAT   = 3'd4;

    // Saturation limits
    localparam logic [VAL_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] Q_MIN = 32'h8000_0000;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [VAL_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [VAL_W-1:0] quotient;
    } t_div_rsp;

    // Saturate a 33-bit signed sum to 32 bits; top bit of the result flags saturation
    function automatic logic [VAL_W:0] sat_wide(input logic [VAL_W:0] v);
        logic [VAL_W:0] res;
        if (v[VAL_W] != v[VAL_W-1]) begin
            res = v[VAL_W] ? {1'b1, Q_MIN} : {1'b1, Q_MAX};
        end else begin
            res = {1'b0, v[VAL_W-1:0]};
        end
        return res;
    endfunction

    // Apply a sign to an unsigned magnitude and saturate; top bit flags saturation
    function automatic logic [VAL_W:0] sat_mag(input logic [47:0] mag, input logic neg);
        logic [VAL_W:0] res;
        if (neg) begin
            if (mag > 48'h0000_8000_0000) begin
                res = {1'b1, Q_MIN};
            end else begin
                res = {1'b0, 32'(32'd0 - mag[VAL_W-1:0])};
            end
        end else begin
            if (mag > 48'h0000_7FFF_FFFF) begin
                res = {1'b1, Q_MAX};
            end else begin
                res = {1'b0, mag[VAL_W-1:0]};
            end
        end
        return res;
    endfunction

    // Magnitude of a signed 32-bit value as unsigned 32 bits
    function automatic logic [VAL_W-1:0] mag_of(input logic [VAL_W-1:0] v);
        return v[VAL_W-1] ? 32'(32'd0 - v) : v;
    endfunction

endpackage

// ===== rtl/rpn_stack_calculator_top.sv =====
// RPN stack calculator: one item in flight, result strobed for one cycle; depends on
// rpn_pkg, rpn_ram and rpn_div. After accept, S_EVAL serves push, pop, add, subtract,
// spare opcodes, underflow and divide by zero; multiply adds S_MUL and S_MUL_DONE, divide
// S_DIV and S_DIV_WAIT (one quotient bit per cycle, or at once on quotient overflow).
// busy falls for the strobe cycle, so the next item can be taken at the edge ending it.
// Synchronous active-low reset empties the stack; no clearing pass is needed.
module rpn_stack_calculator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [rpn_pkg::OP_W-1:0]        i_opcode,
    input  logic signed [rpn_pkg::VAL_W-1:0] i_operand_value,
    output logic                            o_done,
    output logic [rpn_pkg::ST_W-1:0]        o_status,
    output logic signed [rpn_pkg::VAL_W-1:0] o_top_value,
    output logic [rpn_pkg::OUT_DEPTH_W-1:0] o_stack_depth
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_MUL_DONE,
        S_DIV,
        S_DIV_WAIT
    } t_state;

    t_state                      r_state, n_state;
    logic [rpn_pkg::DEPTH_W-1:0] r_depth, n_depth;
    logic                        r_done, n_done;
    logic [rpn_pkg::ST_W-1:0]    r_status, n_status;
    logic [rpn_pkg::VAL_W-1:0]   r_top, n_top;
    logic [rpn_pkg::OP_W-1:0]    r_opcode, n_opcode;
    logic [rpn_pkg::VAL_W-1:0]   r_operand, n_operand;
    logic [rpn_pkg::VAL_W-1:0]   r_mag_l, n_mag_l;
    logic [rpn_pkg::VAL_W-1:0]   r_mag_r, n_mag_r;
    logic                        r_neg, n_neg;
    logic [2*rpn_pkg::VAL_W-1:0] r_prod, n_prod;

    logic                        wr_en;
    logic [rpn_pkg::ADDR_W-1:0]  wr_addr;
    logic [rpn_pkg::VAL_W-1:0]   wr_data;
    logic [rpn_pkg::ADDR_W-1:0]  addr_lo;
    logic [rpn_pkg::ADDR_W-1:0]  addr_hi;
    logic [rpn_pkg::VAL_W-1:0]   rd_lo;
    logic [rpn_pkg::VAL_W-1:0]   rd_hi;
    logic [rpn_pkg::VAL_W-1:0]   cur_top;
    logic [rpn_pkg::VAL_W:0]     sum_res;
    logic [rpn_pkg::VAL_W:0]     diff_res;
    logic [rpn_pkg::VAL_W:0]     mul_res;
    logic [rpn_pkg::VAL_W:0]     div_res;
    logic [47:0]                 div_mag;
    rpn_pkg::t_div_req           div_req;
    rpn_pkg::t_div_rsp           div_rsp;

    // Read second-from-top and top from the current depth
    assign addr_lo = rpn_pkg::ADDR_W'(r_depth - rpn_pkg::DEPTH_W'(2));
    assign addr_hi = rpn_pkg::ADDR_W'(r_depth - rpn_pkg::DEPTH_W'(1));

    rpn_ram #(
        .WIDTH  (rpn_pkg::VAL_W),
        .DEPTH  (rpn_pkg::CAPACITY),
        .ADDR_W (rpn_pkg::ADDR_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (addr_lo),
        .i_rd_addr_b (addr_hi),
        .o_rd_data_a (rd_lo),
        .o_rd_data_b (rd_hi)
    );

    rpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign div_req.start    = (r_state == S_DIV);
    assign div_req.dividend = r_mag_l;
    assign div_req.divisor  = r_mag_r;

    // Arithmetic on the operands and finished products
    assign cur_top  = (r_depth == '0) ? '0 : rd_hi;
    assign sum_res  = rpn_pkg::sat_wide({rd_lo[rpn_pkg::VAL_W-1], rd_lo}
                                        + {rd_hi[rpn_pkg::VAL_W-1], rd_hi});
    assign diff_res = rpn_pkg::sat_wide({rd_lo[rpn_pkg::VAL_W-1], rd_lo}
                                        - {rd_hi[rpn_pkg::VAL_W-1], rd_hi});
    assign mul_res  = rpn_pkg::sat_mag(r_prod[2*rpn_pkg::VAL_W-1:rpn_pkg::FRAC_W], r_neg);
    assign div_mag  = div_rsp.ovf ? 48'h0001_0000_0000 : {16'd0, div_rsp.quotient};
    assign div_res  = rpn_pkg::sat_mag(div_mag, r_neg);

    // Sequence one item: read, evaluate, write back
    always_comb begin
        n_state   = r_state;
        n_depth   = r_depth;
        n_done    = 1'b0;
        n_status  = r_status;
        n_top     = r_top;
        n_opcode  = r_opcode;
        n_operand = r_operand;
        n_mag_l   = r_mag_l;
        n_mag_r   = r_mag_r;
        n_neg     = r_neg;
        n_prod    = r_prod;
        wr_en     = 1'b0;
        wr_addr   = addr_lo;
        wr_data   = r_top;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_opcode  = i_opcode;
                    n_operand = i_operand_value;
                    n_state   = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state  = S_IDLE;
                n_done   = 1'b1;
                n_status = rpn_pkg::ST_OK;
                n_top    = cur_top;
                case (r_opcode)
                    rpn_pkg::OP_PUSH: begin
                        if (r_depth == rpn_pkg::DEPTH_W'(rpn_pkg::CAPACITY)) begin
                            n_status = rpn_pkg::ST_OVER;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = rpn_pkg::ADDR_W'(r_depth);
                            wr_data = r_operand;
                            n_top   = r_operand;
                            n_depth = r_depth + 1'b1;
                        end
                    end
                    rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV: begin
                        if (r_depth < rpn_pkg::DEPTH_W'(2)) begin
                            n_status = rpn_pkg::ST_UNDER;
                        end else if (r_opcode == rpn_pkg::OP_ADD) begin
                            wr_en    = 1'b1;
                            wr_data  = sum_res[rpn_pkg::VAL_W-1:0];
                            n_top    = sum_res[rpn_pkg::VAL_W-1:0];
                            n_status = sum_res[rpn_pkg::VAL_W] ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK;
                            n_depth  = r_depth - 1'b1;
                        end else if (r_opcode == rpn_pkg::OP_SUB) begin
                            wr_en    = 1'b1;
                            wr_data  = diff_res[rpn_pkg::VAL_W-1:0];
                            n_top    = diff_res[rpn_pkg::VAL_W-1:0];
                            n_status = diff_res[rpn_pkg::VAL_W] ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK;
                            n_depth  = r_depth - 1'b1;
                        end else if (r_opcode == rpn_pkg::OP_DIV && rd_hi == '0) begin
                            // Divide by zero: saturate towards the sign of the left operand
                            wr_en    = 1'b1;
                            wr_data  = rd_lo[rpn_pkg::VAL_W-1] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
                            n_top    = wr_data;
                            n_status = rpn_pkg::ST_DIVZ;
                            n_depth  = r_depth - 1'b1;
                        end else begin
                            // Hold magnitudes and sign for the multiplier or divider
                            n_done  = 1'b0;
                            n_mag_l = rpn_pkg::mag_of(rd_lo);
                            n_mag_r = rpn_pkg::mag_of(rd_hi);
                            n_neg   = rd_lo[rpn_pkg::VAL_W-1] ^ rd_hi[rpn_pkg::VAL_W-1];
                            n_state = (r_opcode == rpn_pkg::OP_MUL) ? S_MUL : S_DIV;
                        end
                    end
                    rpn_pkg::OP_POP: begin
                        if (r_depth == '0) begin
                            n_status = rpn_pkg::ST_UNDER;
                        end else begin
                            n_top   = rd_hi;
                            n_depth = r_depth - 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_MUL: begin
                n_prod  = (2*rpn_pkg::VAL_W)'(r_mag_l) * (2*rpn_pkg::VAL_W)'(r_mag_r);
                n_state = S_MUL_DONE;
            end
            S_MUL_DONE: begin
                wr_en    = 1'b1;
                wr_data  = mul_res[rpn_pkg::VAL_W-1:0];
                n_top    = mul_res[rpn_pkg::VAL_W-1:0];
                n_status = mul_res[rpn_pkg::VAL_W] ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK;
                n_depth  = r_depth - 1'b1;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            S_DIV: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    wr_en    = 1'b1;
                    wr_data  = div_res[rpn_pkg::VAL_W-1:0];
                    n_top    = div_res[rpn_pkg::VAL_W-1:0];
                    n_status = div_res[rpn_pkg::VAL_W] ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK;
                    n_depth  = r_depth - 1'b1;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, depth and the registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_done  <= n_done;
        end
        r_status  <= n_status;
        r_top     <= n_top;
        r_opcode  <= n_opcode;
        r_operand <= n_operand;
        r_mag_l   <= n_mag_l;
        r_mag_r   <= n_mag_r;
        r_neg     <= n_neg;
        r_prod    <= n_prod;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_top_value   = r_top;
    assign o_stack_depth = rpn_pkg::OUT_DEPTH_W'(r_depth);

endmodule

// ===== rtl/rpn_ram.sv =====
// Generic single-write, dual-read synchronous RAM with registered read data.
// Stand-alone; no package needed.
module rpn_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]  o_rd_data_a,
    output logic [WIDTH-1:0]  o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // Write one entry, register both reads
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== rtl/rpn_div.sv =====
// Radix-2 restoring divider for Q16.16 magnitudes: (dividend << 16) / divisor.
// Depends on rpn_pkg for the request and response structs.
module rpn_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpn_pkg::t_div_req i_req,
    output rpn_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(rpn_pkg::VAL_W + 1);

    logic                      r_busy;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_done;
    logic                      r_ovf;
    logic [rpn_pkg::VAL_W-1:0] r_rem;
    logic [rpn_pkg::VAL_W-1:0] r_quo;
    logic [rpn_pkg::VAL_W-1:0] r_den;

    logic [rpn_pkg::VAL_W:0]   trial;
    logic [rpn_pkg::VAL_W:0]   diff;
    logic                      q_bit;
    logic                      start_ovf;

    // Quotient would need more than 32 bits when the integer part of the dividend reaches the divisor
    assign start_ovf = {16'd0, i_req.dividend[rpn_pkg::VAL_W-1:rpn_pkg::FRAC_W]}
                       >= i_req.divisor;

    // One trial subtraction per cycle
    assign trial = {r_rem, r_quo[rpn_pkg::VAL_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign q_bit = !diff[rpn_pkg::VAL_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                // Load, or finish at once on overflow
                r_den <= i_req.divisor;
                r_rem <= {16'd0, i_req.dividend[rpn_pkg::VAL_W-1:rpn_pkg::FRAC_W]};
                r_quo <= {i_req.dividend[rpn_pkg::FRAC_W-1:0], 16'd0};
                r_ovf <= start_ovf;
                if (start_ovf) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(rpn_pkg::VAL_W);
                end
            end else if (r_busy) begin
                // Advance one quotient bit
                r_rem <= q_bit ? diff[rpn_pkg::VAL_W-1:0] : trial[rpn_pkg::VAL_W-1:0];
                r_quo <= {r_quo[rpn_pkg::VAL_W-2:0], q_bit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.ovf      = r_ovf;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== tb/tb_rpn_stack_calculator_top.sv =====
// Self-checking testbench for rpn_stack_calculator_top: command items in, one strobed
// result per item out, checked against a stack predictor kept inside this module.
// Depends on rpn_pkg and the top level with its submodules.
module tb_rpn_stack_calculator_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Opcodes the block treats as no operation
    localparam logic [rpn_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [rpn_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam int                        ITEM_TARGET = 1050;
    localparam logic [rpn_pkg::VAL_W-1:0] Q_ONE       = 32'h0001_0000;
    localparam logic [rpn_pkg::VAL_W-1:0] Q_NEG_ONE   = 32'hFFFF_0000;
    localparam longint                    Q_HI        = longint'(signed'(rpn_pkg::Q_MAX));
    localparam longint                    Q_LO        = longint'(signed'(rpn_pkg::Q_MIN));

    typedef struct packed {
        logic [rpn_pkg::OP_W-1:0]  op;
        logic [rpn_pkg::VAL_W-1:0] val;
    } t_calc_cmd;

    typedef struct packed {
        logic [rpn_pkg::ST_W-1:0]        status;
        logic [rpn_pkg::VAL_W-1:0]       top;
        logic [rpn_pkg::OUT_DEPTH_W-1:0] depth;
    } t_calc_res;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic [rpn_pkg::OP_W-1:0]        i_opcode = '0;
    logic signed [rpn_pkg::VAL_W-1:0] i_operand_value = '0;
    logic                            o_done;
    logic [rpn_pkg::ST_W-1:0]        o_status;
    logic signed [rpn_pkg::VAL_W-1:0] o_top_value;
    logic [rpn_pkg::OUT_DEPTH_W-1:0] o_stack_depth;

    t_calc_cmd                 cmd_queue[$];
    t_calc_res                 expected_results[$];
    logic [rpn_pkg::VAL_W-1:0] model_stack [rpn_pkg::CAPACITY];
    int                        model_depth = 0;
    int                        plan_depth = 0;
    int                        items_driven = 0;
    int                        mismatch_count = 0;
    logic                      taken = 1'b0;

    rpn_stack_calculator_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_operand_value (i_operand_value),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_top_value     (o_top_value),
        .o_stack_depth   (o_stack_depth)
    );

    always #5 i_clk = ~i_clk;

    // Clamp a wide signed result into Q16.16, flagging saturation
    function automatic logic [rpn_pkg::VAL_W-1:0] clamp_q(input longint v,
                                                          inout logic [rpn_pkg::ST_W-1:0] st);
        if (v > Q_HI) begin
            st = rpn_pkg::ST_SAT;
            return rpn_pkg::Q_MAX;
        end
        if (v < Q_LO) begin
            st = rpn_pkg::ST_SAT;
            return rpn_pkg::Q_MIN;
        end
        return v[rpn_pkg::VAL_W-1:0];
    endfunction

    // Apply one item to the model stack and return the result it should produce
    function automatic t_calc_res evaluate_item(input t_calc_cmd cmd);
        t_calc_res                 res;
        longint                    lhs, rhs, mag_l, mag_r, wide;
        logic                      neg;
        logic                      popped;
        logic [rpn_pkg::VAL_W-1:0] folded;
        logic [rpn_pkg::VAL_W-1:0] popped_val;
        logic [rpn_pkg::ST_W-1:0]  st;
        st = rpn_pkg::ST_OK;
        popped = 1'b0;
        popped_val = '0;
        folded = '0;
        lhs = 0;
        rhs = 0;
        if (model_depth >= 2) begin
            lhs = longint'(signed'(model_stack[model_depth-2]));
            rhs = longint'(signed'(model_stack[model_depth-1]));
        end
        mag_l = (lhs < 0) ? -lhs : lhs;
        mag_r = (rhs < 0) ? -rhs : rhs;
        neg = (lhs < 0) != (rhs < 0);
        case (cmd.op)
            rpn_pkg::OP_PUSH: begin
                if (model_depth >= rpn_pkg::CAPACITY) begin
                    st = rpn_pkg::ST_OVER;
                end else begin
                    model_stack[model_depth] = cmd.val;
                    model_depth++;
                end
            end
            rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV: begin
                if (model_depth < 2) begin
                    st = rpn_pkg::ST_UNDER;
                end else begin
                    case (cmd.op)
                        rpn_pkg::OP_ADD: folded = clamp_q(lhs + rhs, st);
                        rpn_pkg::OP_SUB: folded = clamp_q(lhs - rhs, st);
                        rpn_pkg::OP_MUL: begin
                            wide = (mag_l * mag_r) >>> rpn_pkg::FRAC_W;
                            folded = clamp_q(neg ? -wide : wide, st);
                        end
                        default: begin
                            if (rhs == 0) begin
                                st = rpn_pkg::ST_DIVZ;
                                folded = (lhs >= 0) ? rpn_pkg::Q_MAX : rpn_pkg::Q_MIN;
                            end else begin
                                wide = (mag_l <<< rpn_pkg::FRAC_W) / mag_r;
                                folded = clamp_q(neg ? -wide : wide, st);
                            end
                        end
                    endcase
                    model_depth--;
                    model_stack[model_depth-1] = folded;
                end
            end
            rpn_pkg::OP_POP: begin
                if (model_depth == 0) begin
                    st = rpn_pkg::ST_UNDER;
                end else begin
                    model_depth--;
                    popped = 1'b1;
                    popped_val = model_stack[model_depth];
                end
            end
            default: ;
        endcase
        res.status = st;
        if (popped)
            res.top = popped_val;
        else
            res.top = (model_depth == 0) ? '0 : model_stack[model_depth-1];
        res.depth = rpn_pkg::OUT_DEPTH_W'(model_depth);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input t_calc_res want,
                                   input t_calc_res got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected status %0d top %h depth %0d, got status %0d top %h depth %0d",
                     $time, what, want.status, want.top, want.depth,
                     got.status, got.top, got.depth);
    endtask

    // Stimulus helpers: the planned depth only shapes sequences, it checks nothing
    task automatic queue_cmd(input logic [rpn_pkg::OP_W-1:0] op,
                             input logic [rpn_pkg::VAL_W-1:0] val);
        t_calc_cmd cmd;
        cmd.op = op;
        cmd.val = val;
        cmd_queue.push_back(cmd);
        case (op)
            rpn_pkg::OP_PUSH: if (plan_depth < rpn_pkg::CAPACITY) plan_depth++;
            rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV:
                if (plan_depth >= 2) plan_depth--;
            rpn_pkg::OP_POP: if (plan_depth > 0) plan_depth--;
            default: ;
        endcase
    endtask

    function automatic logic [rpn_pkg::OP_W-1:0] random_arith();
        case ($urandom_range(3))
            0: return rpn_pkg::OP_ADD;
            1: return rpn_pkg::OP_SUB;
            2: return rpn_pkg::OP_MUL;
            default: return rpn_pkg::OP_DIV;
        endcase
    endfunction

    function automatic logic [rpn_pkg::VAL_W-1:0] pick_value();
        logic [15:0] whole;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                whole = 16'($urandom_range(400)) - 16'd200;
                return {whole, 16'($urandom)};
            end
            4: return '0;
            5: return $urandom_range(1) ? Q_ONE : Q_NEG_ONE;
            6: return $urandom_range(1) ? rpn_pkg::Q_MAX : rpn_pkg::Q_MIN;
            default: return $urandom;
        endcase
    endfunction

    // Fill to capacity, push past it, fold back down to one value and pop past empty
    task automatic fill_and_drain();
        while (plan_depth < rpn_pkg::CAPACITY)
            queue_cmd(rpn_pkg::OP_PUSH, pick_value());
        repeat (2) queue_cmd(rpn_pkg::OP_PUSH, pick_value());
        queue_cmd(OP_SPARE6, $urandom);
        while (plan_depth > 1)
            queue_cmd(random_arith(), $urandom);
        repeat (2) queue_cmd(rpn_pkg::OP_POP, $urandom);
    endtask

    // Drive items at the falling edge; hold an item until it has been taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !taken) begin
        end else if (cmd_queue.size() != 0 &&
                     ((items_driven >= 400 && items_driven < 600) ||
                      $urandom_range(99) >= 37)) begin
            start <= 1'b1;
            i_opcode <= cmd_queue[0].op;
            i_operand_value <= cmd_queue[0].val;
            void'(cmd_queue.pop_front());
            items_driven++;
        end else begin
            start <= 1'b0;
            i_opcode <= rpn_pkg::OP_W'($urandom);
            i_operand_value <= $urandom;
        end
    end

    // Check strobed results, then record the item taken at this edge
    always @(posedge i_clk) begin : result_check
        t_calc_cmd seen_cmd;
        t_calc_res got;
        if (!i_rst_n) begin
            taken <= 1'b0;
        end else begin
            if (o_done) begin
                got.status = o_status;
                got.top = o_top_value;
                got.depth = o_stack_depth;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no item outstanding", '0, got);
                end else begin
                    if (got.status !== expected_results[0].status ||
                        got.top !== expected_results[0].top ||
                        got.depth !== expected_results[0].depth)
                        report_mismatch("result mismatch", expected_results[0], got);
                    void'(expected_results.pop_front());
                end
            end
            taken <= start && !busy;
            if (start && !busy) begin
                seen_cmd.op = i_opcode;
                seen_cmd.val = i_operand_value;
                expected_results.push_back(evaluate_item(seen_cmd));
            end
        end
    end

    // Build the item list, run it through and give the verdict
    initial begin
        int n;
        logic refilled;
        refilled = 1'b0;

        // Empty-stack cases and the saturating corners
        queue_cmd(rpn_pkg::OP_POP, $urandom);
        queue_cmd(rpn_pkg::OP_ADD, $urandom);
        queue_cmd(rpn_pkg::OP_PUSH, rpn_pkg::Q_MAX);
        queue_cmd(rpn_pkg::OP_SUB, $urandom);
        queue_cmd(OP_SPARE6, $urandom);
        queue_cmd(rpn_pkg::OP_PUSH, rpn_pkg::Q_MAX);
        queue_cmd(rpn_pkg::OP_ADD, $urandom);
        queue_cmd(rpn_pkg::OP_PUSH, rpn_pkg::Q_MIN);
        queue_cmd(rpn_pkg::OP_SUB, $urandom);
        queue_cmd(rpn_pkg::OP_PUSH, rpn_pkg::Q_MIN);
        queue_cmd(rpn_pkg::OP_MUL, $urandom);
        queue_cmd(rpn_pkg::OP_PUSH, Q_NEG_ONE);
        queue_cmd(rpn_pkg::OP_DIV, $urandom);
        queue_cmd(rpn_pkg::OP_PUSH, '0);
        queue_cmd(rpn_pkg::OP_DIV, $urandom);
        queue_cmd(rpn_pkg::OP_POP, $urandom);
        queue_cmd(rpn_pkg::OP_PUSH, rpn_pkg::Q_MIN);
        queue_cmd(rpn_pkg::OP_PUSH, '0);
        queue_cmd(rpn_pkg::OP_DIV, $urandom);
        queue_cmd(rpn_pkg::OP_PUSH, 32'h0001_8000);
        queue_cmd(rpn_pkg::OP_PUSH, 32'hFFFE_0000);
        queue_cmd(rpn_pkg::OP_MUL, $urandom);
        queue_cmd(OP_SPARE7, $urandom);
        queue_cmd(rpn_pkg::OP_POP, $urandom);
        queue_cmd(rpn_pkg::OP_POP, $urandom);
        fill_and_drain();

        // Mostly well-formed expressions, with some noise between them
        while (cmd_queue.size() < ITEM_TARGET) begin
            if (!refilled && cmd_queue.size() > 550) begin
                refilled = 1'b1;
                fill_and_drain();
            end else if ($urandom_range(99) < 75) begin
                n = $urandom_range(2, 6);
                if ($urandom_range(1) != 0) begin
                    repeat (n) queue_cmd(rpn_pkg::OP_PUSH, pick_value());
                    repeat (n - 1) queue_cmd(random_arith(), $urandom);
                end else begin
                    queue_cmd(rpn_pkg::OP_PUSH, pick_value());
                    repeat (n - 1) begin
                        queue_cmd(rpn_pkg::OP_PUSH, pick_value());
                        queue_cmd(random_arith(), $urandom);
                    end
                end
                if ($urandom_range(2) != 0 || plan_depth > 40)
                    queue_cmd(rpn_pkg::OP_POP, $urandom);
            end else begin
                repeat ($urandom_range(1, 4))
                    queue_cmd(rpn_pkg::OP_PUSH + rpn_pkg::OP_W'($urandom_range(7)),
                              pick_value());
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || start || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("rpn_stack_calculator_top verification clean");
        end else begin
            $display("rpn_stack_calculator_top verification failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #(5_000_000);
        $display("rpn_stack_calculator_top verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rpn_pkg.sv
rtl/rpn_ram.sv
rtl/rpn_div.sv
rtl/rpn_stack_calculator_top.sv
tb/tb_rpn_stack_calculator_top.sv
